// ===== rtl/mtx4_pkg.sv =====
// Shared types, constants and helpers for the 4x4 fixed-point matrix multiplier.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package mtx4_pkg;

	// Element format: signed fixed point, ELEM_W bits with FRAC_W fraction bits
	localparam int ELEM_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	// four products summed: two guard bits keep the sum exact
	localparam int ACC_W  = PROD_W + 2;
	localparam int SAT_LO = FRAC_W + ELEM_W - 1;

	localparam logic [ELEM_W-1:0] IDENT_ONE = ELEM_W'(64'd1 << FRAC_W);
	localparam logic [ELEM_W-1:0] ELEM_MAX  = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] ELEM_MIN  = {1'b1, {(ELEM_W-1){1'b0}}};

	// Command codes
	localparam logic [1:0] CMD_WR_LEFT  = 2'd0;
	localparam logic [1:0] CMD_WR_RIGHT = 2'd1;
	localparam logic [1:0] CMD_COMPUTE  = 2'd2;

	// Input item
	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         elem_index;
		logic signed [31:0] elem_value;
	} mtx4_item_t;

	// Result item
	typedef struct packed {
		logic signed [31:0] prod_value;
		logic [3:0]         prod_index;
		logic               sat_flag;
		logic               last_elem;
	} mtx4_result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       wr_left;
		logic       wr_right;
		logic       issue;   // one multiply-add step this cycle
		logic [5:0] step;    // {row, col, k}
	} mtx4_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fin_done;      // final product element is on the output
	} mtx4_stat_t;

	// Identity matrix reset value for a row-major position
	function automatic logic [ELEM_W-1:0] ident_elem(input logic [3:0] idx);
		ident_elem = (idx[3:2] == idx[1:0]) ? IDENT_ONE : '0;
	endfunction

endpackage

// ===== rtl/mtx4_dpath.sv =====
// Datapath: matrix element registers, shared MAC pipeline, floor shift and saturation.
// Depends on mtx4_pkg.
`timescale 1ns / 1ps

module mtx4_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mtx4_pkg::mtx4_item_t  item,
	input  mtx4_pkg::mtx4_cmd_t   cmd,
	output mtx4_pkg::mtx4_stat_t  stat,
	output logic                  strobe,
	output mtx4_pkg::mtx4_result_t result
);

	logic [mtx4_pkg::ELEM_W-1:0] left_q  [16];
	logic [mtx4_pkg::ELEM_W-1:0] right_q [16];

	logic [1:0] row, col, kk;

	logic signed [mtx4_pkg::ELEM_W-1:0] a_s1, b_s1;
	logic        vld_s1, first_s1, last_s1;
	logic [3:0]  pos_s1;

	logic signed [mtx4_pkg::PROD_W-1:0] p_s2;
	logic        vld_s2, first_s2, last_s2;
	logic [3:0]  pos_s2;

	logic signed [mtx4_pkg::ACC_W-1:0] acc_q;
	logic        fin_s3;
	logic [3:0]  pos_s3;

	logic signed [mtx4_pkg::ACC_W-1:0] p_ext;
	logic [mtx4_pkg::ACC_W-1:mtx4_pkg::SAT_LO] acc_hi;
	logic        no_clip;

	logic                   strobe_q;
	mtx4_pkg::mtx4_result_t result_q;

	assign row = cmd.step[5:4];
	assign col = cmd.step[3:2];
	assign kk  = cmd.step[1:0];

	// Element registers, reset to identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				left_q[i]  <= mtx4_pkg::ident_elem(4'(i));
				right_q[i] <= mtx4_pkg::ident_elem(4'(i));
			end
		end else begin
			if (cmd.wr_left)
				left_q[item.elem_index] <= item.elem_value[mtx4_pkg::ELEM_W-1:0];
			if (cmd.wr_right)
				right_q[item.elem_index] <= item.elem_value[mtx4_pkg::ELEM_W-1:0];
		end
	end

	// Stage 1: operand fetch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		a_s1     <= left_q[{row, kk}];
		b_s1     <= right_q[{kk, col}];
		first_s1 <= (kk == 2'd0);
		last_s1  <= (kk == 2'd3);
		pos_s1   <= {row, col};
	end

	// Stage 2: signed multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s2     <= mtx4_pkg::PROD_W'(a_s1 * b_s1);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		pos_s2   <= pos_s1;
	end

	// Stage 3: accumulate four products exactly
	assign p_ext = mtx4_pkg::ACC_W'(p_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s3 <= 1'b0;
		end else begin
			fin_s3 <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2)
			acc_q <= first_s2 ? p_ext : acc_q + p_ext;
		pos_s3 <= pos_s2;
	end

	// Floor shift is a bit-select; clip when the bits above the result are not all sign
	assign acc_hi  = acc_q[mtx4_pkg::ACC_W-1:mtx4_pkg::SAT_LO];
	assign no_clip = (&acc_hi) || !(|acc_hi);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= fin_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s3) begin
			if (no_clip)
				result_q.prod_value <= acc_q[mtx4_pkg::SAT_LO:mtx4_pkg::FRAC_W];
			else if (acc_q[mtx4_pkg::ACC_W-1])
				result_q.prod_value <= mtx4_pkg::ELEM_MIN;
			else
				result_q.prod_value <= mtx4_pkg::ELEM_MAX;
			result_q.prod_index <= pos_s3;
			result_q.sat_flag   <= !no_clip;
			result_q.last_elem  <= (pos_s3 == 4'd15);
		end
	end

	assign strobe        = strobe_q;
	assign result        = result_q;
	assign stat.fin_done = strobe_q && result_q.last_elem;

endmodule

// ===== rtl/mtx4_ctrl.sv =====
// Controller: accepts items, sequences the 64 multiply-add steps of a compute.
// Depends on mtx4_pkg.
`timescale 1ns / 1ps

module mtx4_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           item_cmd,
	input  mtx4_pkg::mtx4_stat_t stat,
	output logic                 busy,
	output mtx4_pkg::mtx4_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [5:0] step_q;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept && item_cmd == mtx4_pkg::CMD_COMPUTE)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (stat.fin_done)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Commands to datapath
	assign cmd.wr_left  = accept && (item_cmd == mtx4_pkg::CMD_WR_LEFT);
	assign cmd.wr_right = accept && (item_cmd == mtx4_pkg::CMD_WR_RIGHT);
	assign cmd.issue    = (state_q == ST_RUN);
	assign cmd.step     = step_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fin_done |-> state_q == ST_DRAIN)
		else $error("final result outside drain");

	a_run_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == 6'd63) |=> state_q == ST_DRAIN)
		else $error("run did not end after 64 steps");

	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> (state_q != ST_RUN || step_q == 6'd0))
		else $error("run started at nonzero step");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_left || cmd.wr_right) |-> state_q == ST_IDLE)
		else $error("element write while busy");

endmodule

// ===== rtl/matrix4x4_multiply.sv =====
// 4x4 signed Q16.16 matrix multiplier. Write: busy stays low.
// Compute: 64 multiply-adds on one shared MAC, one step per cycle; results are strobed
// one by one in row-major order, and busy stays high until the last one is strobed.
// Results carry a one-cycle strobe and cannot be stalled.
// Reset (arst_n low, asynchronous) loads both matrices with identity.
`timescale 1ns / 1ps

module matrix4x4_multiply (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  mtx4_pkg::mtx4_item_t   item,
	output logic                   strobe,
	output mtx4_pkg::mtx4_result_t result
);

	mtx4_pkg::mtx4_cmd_t  cmd;
	mtx4_pkg::mtx4_stat_t stat;

	mtx4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item_cmd (item.cmd),
		.stat     (stat),
		.busy     (busy),
		.cmd      (cmd)
	);

	mtx4_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule
